// ===== rtl/gvaq_pkg.sv =====
// Shared types, constants and helper functions for the graded voltage alarm qualifier.
`default_nettype none

package gvaq_pkg;

    // Field and counter widths
    localparam int SAMPLE_W   = 16;
    localparam int TH_W       = 15;
    localparam int TRIG_W     = 8;
    localparam int OUT_CNT_W  = 8;
    localparam int CNT_W      = 8;
    localparam int CMP_W      = (CNT_W > TRIG_W) ? CNT_W : TRIG_W;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_ADDR_W-1:0] REG_WARN_TH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ERR_TH    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_TRIG = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ERR_TRIG  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_WARN_REC  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_ERR_REC   = 3'd5;

    // Reset values of the configuration registers
    localparam logic [TH_W-1:0]   RST_WARN_TH   = 15'd300;
    localparam logic [TH_W-1:0]   RST_ERR_TH    = 15'd1500;
    localparam logic [TRIG_W-1:0] RST_WARN_TRIG = 8'd3;
    localparam logic [TRIG_W-1:0] RST_ERR_TRIG  = 8'd5;
    localparam logic [TRIG_W-1:0] RST_WARN_REC  = 8'd10;
    localparam logic [TRIG_W-1:0] RST_ERR_REC   = 8'd15;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_INFO = 2'd1,
        LVL_WARN = 2'd2,
        LVL_ERR  = 2'd3
    } level_t;

    typedef struct packed {
        logic [TH_W-1:0]   warn_th;
        logic [TH_W-1:0]   err_th;
        logic [TRIG_W-1:0] warn_trig;
        logic [TRIG_W-1:0] err_trig;
        logic [TRIG_W-1:0] warn_rec;
        logic [TRIG_W-1:0] err_rec;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] accum;
        logic [CNT_W-1:0] warn_safe;
        logic [CNT_W-1:0] err_safe;
        logic             warn_flag;
        logic             err_flag;
        level_t           level;
    } state_t;

    // Saturating counter add of a small increment
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] cnt,
                                                 input logic [1:0] inc);
        logic [CNT_W:0] s;
        s = {1'b0, cnt} + (CNT_W + 1)'(inc);
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    // Counter at or above an 8-bit register value
    function automatic logic cnt_ge(input logic [CNT_W-1:0] cnt,
                                    input logic [TRIG_W-1:0] lim);
        return CMP_W'(cnt) >= CMP_W'(lim);
    endfunction

    // Register value limited to the counter range
    function automatic logic [CNT_W-1:0] clamp_cnt(input logic [TRIG_W-1:0] lim);
        return (CMP_W'(lim) > CMP_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(lim);
    endfunction

    // Low bits of a counter as a result field
    function automatic logic [OUT_CNT_W-1:0] to_out(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OUT_CNT_W-1:0] e;
        e = {{OUT_CNT_W{1'b0}}, cnt};
        return e[OUT_CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/graded_voltage_alarm_qualifier.sv =====
// Top level of the graded voltage alarm qualifier: request registers, state and result register.
//
// Usage:
//   Input channel s_valid/s_ready carries one signed millivolt sample per request.
//   Result channel m_valid/m_ready returns one result per sample, in order: the alarm
//   level, the alert flag and the alarm and recovery counts after that sample.
//   Configuration is written through cfg_wr_en/cfg_addr/cfg_wr_data, one register per
//   cycle, only while no sample is in flight; indexes 6 and 7 are ignored.
// Flow:
//   A taken sample sits in the input register and is qualified into the result register
//   once the result slot is free or is being drained; the registered m_valid then
//   holds the result until it is taken.
//   One sample per cycle is sustained while m_ready stays high; the rate is set by the
//   combinational state update between the input register and the result register.
// Reset:
//   aresetn (synchronous, low) empties both registers, clears all counters and
//   flags, sets the level to none and loads the default thresholds, triggers and recovery counts.
// Backpressure:
//   While m_ready is low the result holds; the input register still takes one more
//   sample, then s_ready drops until the result is taken.
`default_nettype none

module graded_voltage_alarm_qualifier (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [gvaq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [gvaq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // Sample channel
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic signed [gvaq_pkg::SAMPLE_W-1:0] s_sample_mv,
    // Result channel
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [1:0]                       m_alarm_level,
    output      logic                             m_alert_active,
    output      logic [gvaq_pkg::OUT_CNT_W-1:0]   m_trigger_count,
    output      logic [gvaq_pkg::OUT_CNT_W-1:0]   m_warn_safe_count,
    output      logic [gvaq_pkg::OUT_CNT_W-1:0]   m_err_safe_count
);

    gvaq_pkg::cfg_t   cfg;
    gvaq_pkg::state_t state_reg;
    gvaq_pkg::state_t state_next;

    logic                            in_valid_reg;
    logic [gvaq_pkg::SAMPLE_W-1:0]   in_sample_reg;
    logic                            out_valid_reg;
    logic [1:0]                      out_level_reg;
    logic                            out_alert_reg;
    logic [gvaq_pkg::OUT_CNT_W-1:0]  out_trig_reg;
    logic [gvaq_pkg::OUT_CNT_W-1:0]  out_wsafe_reg;
    logic [gvaq_pkg::OUT_CNT_W-1:0]  out_esafe_reg;
    logic                            advance;

    gvaq_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    gvaq_update u_update (
        .sample_mv (in_sample_reg),
        .cfg       (cfg),
        .cur       (state_reg),
        .nxt       (state_next)
    );

    // Handshake: the held request moves on when the result slot is free or drains
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_sample_reg <= s_sample_mv;
        end
    end

    // Qualifier state, updated once per processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.accum     <= '0;
            state_reg.warn_safe <= '0;
            state_reg.err_safe  <= '0;
            state_reg.warn_flag <= 1'b0;
            state_reg.err_flag  <= 1'b0;
            state_reg.level     <= gvaq_pkg::LVL_NONE;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_level_reg <= state_next.level;
            out_alert_reg <= state_next.warn_flag || state_next.err_flag;
            out_trig_reg  <= gvaq_pkg::to_out(state_next.accum);
            out_wsafe_reg <= gvaq_pkg::to_out(state_next.warn_safe);
            out_esafe_reg <= gvaq_pkg::to_out(state_next.err_safe);
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_alarm_level     = out_level_reg;
    assign m_alert_active    = out_alert_reg;
    assign m_trigger_count   = out_trig_reg;
    assign m_warn_safe_count = out_wsafe_reg;
    assign m_err_safe_count  = out_esafe_reg;

`ifndef SYNTH
    // Error flag is only ever raised together with the warning flag
    a_err_implies_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.err_flag |-> state_reg.warn_flag)
        else $error("error flag set without warning flag");

    // Alert output tracks warning or error level
    a_alert_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_alert_active == ((m_alarm_level == gvaq_pkg::LVL_WARN) ||
                                        (m_alarm_level == gvaq_pkg::LVL_ERR))))
        else $error("alert flag disagrees with alarm level");

    // A held request that cannot move stays held
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input request lost while stalled");

    // Reset empties both registers
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("registers not empty after reset");
`endif

endmodule

`default_nettype wire

// ===== rtl/gvaq_cfg_regs.sv =====
// Configuration register bank of the graded voltage alarm qualifier.
`default_nettype none

module gvaq_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [gvaq_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [gvaq_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output gvaq_pkg::cfg_t                        cfg
);

    gvaq_pkg::cfg_t cfg_reg;
    gvaq_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes leave the bank alone
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                gvaq_pkg::REG_WARN_TH:   cfg_next.warn_th   = cfg_wr_data[gvaq_pkg::TH_W-1:0];
                gvaq_pkg::REG_ERR_TH:    cfg_next.err_th    = cfg_wr_data[gvaq_pkg::TH_W-1:0];
                gvaq_pkg::REG_WARN_TRIG: cfg_next.warn_trig = cfg_wr_data[gvaq_pkg::TRIG_W-1:0];
                gvaq_pkg::REG_ERR_TRIG:  cfg_next.err_trig  = cfg_wr_data[gvaq_pkg::TRIG_W-1:0];
                gvaq_pkg::REG_WARN_REC:  cfg_next.warn_rec  = cfg_wr_data[gvaq_pkg::TRIG_W-1:0];
                gvaq_pkg::REG_ERR_REC:   cfg_next.err_rec   = cfg_wr_data[gvaq_pkg::TRIG_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.warn_th   <= gvaq_pkg::RST_WARN_TH;
            cfg_reg.err_th    <= gvaq_pkg::RST_ERR_TH;
            cfg_reg.warn_trig <= gvaq_pkg::RST_WARN_TRIG;
            cfg_reg.err_trig  <= gvaq_pkg::RST_ERR_TRIG;
            cfg_reg.warn_rec  <= gvaq_pkg::RST_WARN_REC;
            cfg_reg.err_rec   <= gvaq_pkg::RST_ERR_REC;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/gvaq_update.sv =====
// Next-state logic of the alarm qualifier for one sample.
`default_nettype none

module gvaq_update (
    input  wire logic [gvaq_pkg::SAMPLE_W-1:0] sample_mv,
    input  wire gvaq_pkg::cfg_t                cfg,
    input  wire gvaq_pkg::state_t              cur,
    output gvaq_pkg::state_t                   nxt
);

    logic [gvaq_pkg::TH_W-1:0] v;
    logic                      no_flag;
    logic                      safe;

    // Negative samples count as zero
    assign v       = sample_mv[gvaq_pkg::SAMPLE_W-1] ? '0 : sample_mv[gvaq_pkg::TH_W-1:0];
    assign no_flag = !cur.err_flag && !cur.warn_flag;
    assign safe    = v < cfg.warn_th;

    always_comb begin
        nxt = cur;

        // Accumulate and qualify while no alarm is raised
        if (no_flag) begin
            if (v >= cfg.err_th) begin
                nxt.accum = gvaq_pkg::sat_add(cur.accum, 2'd2);
            end else if (v >= cfg.warn_th) begin
                nxt.accum = gvaq_pkg::sat_add(cur.accum, 2'd1);
            end
            if (gvaq_pkg::cnt_ge(nxt.accum, cfg.err_trig)) begin
                nxt.level     = gvaq_pkg::LVL_ERR;
                nxt.err_flag  = 1'b1;
                nxt.warn_flag = 1'b1;
                nxt.accum     = gvaq_pkg::clamp_cnt(cfg.err_trig);
            end else if (gvaq_pkg::cnt_ge(nxt.accum, cfg.warn_trig)) begin
                nxt.level     = gvaq_pkg::LVL_WARN;
                nxt.warn_flag = 1'b1;
            end
        end

        // Recovery counting on low samples, reset on high ones
        if (safe) begin
            if (nxt.level == gvaq_pkg::LVL_ERR) begin
                nxt.err_safe = gvaq_pkg::sat_add(cur.err_safe, 2'd1);
                if (gvaq_pkg::cnt_ge(nxt.err_safe, cfg.err_rec)) begin
                    nxt.err_safe  = '0;
                    nxt.warn_safe = '0;
                    nxt.accum     = '0;
                    nxt.warn_flag = 1'b0;
                    nxt.err_flag  = 1'b0;
                    nxt.level     = gvaq_pkg::LVL_INFO;
                end
            end else if (nxt.warn_flag) begin
                nxt.warn_safe = gvaq_pkg::sat_add(cur.warn_safe, 2'd1);
                if (gvaq_pkg::cnt_ge(nxt.warn_safe, cfg.warn_rec)) begin
                    nxt.warn_safe = '0;
                    nxt.accum     = '0;
                    nxt.warn_flag = 1'b0;
                    nxt.level     = gvaq_pkg::LVL_INFO;
                end
            end
        end else begin
            nxt.warn_safe = '0;
            nxt.err_safe  = '0;
        end
    end

endmodule

`default_nettype wire
